>>> hw/rtl/kws_pkg.sv
// Shared types, constants and helpers for the keyboard wavetable synthesizer.
// Used by the synthesizer top level and its protocol checker; no dependencies.
package kws_pkg;

  // Table and voice geometry
  localparam int TABLE_DEPTH  = 48000;
  localparam int TABLE_AW     = 16;
  localparam int VOICE_COUNT  = 8;
  localparam int VOICE_W      = 3;
  localparam int SAMPLE_BITS  = 24;
  localparam int SUM_W        = SAMPLE_BITS + VOICE_W;
  localparam int VOLUME_MAX   = 10;
  localparam int VOLUME_W     = 4;
  localparam int STEP_W       = 15;
  localparam int TIME_W       = 16;
  localparam int OUT_W        = 31;

  // Modulo by the table depth: depth = odd part << DEPTH_SHIFT
  localparam int DEPTH_SHIFT  = 7;
  localparam int DEPTH_ODD    = TABLE_DEPTH >> DEPTH_SHIFT;
  localparam int PHASE_W      = STEP_W + TIME_W;
  localparam int HIGH_W       = PHASE_W - DEPTH_SHIFT;
  localparam int QUOT_W       = 16;
  localparam int REM_W        = 9;
  localparam int RECIP_SHIFT  = HIGH_W + REM_W;
  localparam longint RECIP    = ((64'd1 << RECIP_SHIFT) + DEPTH_ODD - 1) / DEPTH_ODD;
  localparam int RECIP_W      = 25;

  // Shared multiplier operand widths
  localparam int MUL_AW       = 28;
  localparam int MUL_BW       = 26;
  localparam int MUL_PW       = MUL_AW + MUL_BW;

  // Request types
  typedef enum logic [1:0] {
    REQ_TABLE = 2'd0,
    REQ_SCAN  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Scan codes
  localparam logic [7:0] CODE_BREAK    = 8'hF0;
  localparam logic [7:0] CODE_VOL_UP   = 8'h49;
  localparam logic [7:0] CODE_VOL_DOWN = 8'h41;

  typedef logic [7:0] code_t;
  localparam code_t KEY_CODES [VOICE_COUNT] = '{
    8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h3B, 8'h42, 8'h4B, 8'h4C
  };

  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_RESET [VOICE_COUNT] = '{
    15'd130, 15'd146, 15'd164, 15'd174, 15'd195, 15'd220, 15'd246, 15'd261
  };

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL_PHASE,
    ST_MUL_RECIP,
    ST_MUL_BACK,
    ST_FIX,
    ST_READ,
    ST_ACC,
    ST_SCALE,
    ST_DONE
  } state_t;

  // Note key lookup: hit flag and voice number
  typedef struct packed {
    logic               hit;
    logic [VOICE_W-1:0] voice;
  } key_hit_t;

  function automatic key_hit_t key_lookup(input logic [7:0] code);
    key_hit_t r;
    r = '0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (code == KEY_CODES[i]) begin
        r.hit   = 1'b1;
        r.voice = VOICE_W'(i);
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/kws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/keyboard_wavetable_synth.sv
// Top level of the eight-voice wavetable synthesizer.
// Depends on kws_pkg and the generic RAM kws_ram for the sine table.
// Table writes and scan codes are taken while idle and do not make the block busy. A tick
// walks the held voices in turn and holds req_stall high until its result is registered and
// the sequencer is back in idle; the work uses one shared multiplier three times per voice
// (phase product, reciprocal divide by 375, back-multiply) and the table read port.
// Synchronous active-high reset: voices released, volume one, time zero; table unset.
module keyboard_wavetable_synth
  import kws_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [VOICE_W-1:0]            cfg_index,
  input  logic [STEP_W-1:0]             cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    req_type,
  input  logic [7:0]                    scan_code,
  input  logic [TABLE_AW-1:0]           table_index,
  input  logic signed [SAMPLE_BITS-1:0] table_value,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [OUT_W-1:0]       sample_out,
  output logic [VOLUME_W-1:0]           volume_level
);

  state_t state, state_next;

  step_t                     note_step [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]    voice_held;
  logic                      release_armed;
  logic [VOLUME_W-1:0]       volume;
  logic [TIME_W-1:0]         sample_time;
  logic [VOICE_W-1:0]        voice;
  logic [HIGH_W-1:0]         phase_high;
  logic [DEPTH_SHIFT-1:0]    phase_low;
  logic [TABLE_AW-1:0]       rd_addr;
  logic signed [SUM_W-1:0]   sum;
  logic signed [MUL_PW-1:0]  prod;

  logic                      accept;
  logic                      last_voice;
  logic                      res_free;
  logic                      table_we;
  logic [SAMPLE_BITS-1:0]    table_rdata;
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [MUL_PW-1:0]  mul_p;
  logic [REM_W-1:0]          phase_rem;
  key_hit_t                  key;

  assign accept     = req_valid && !req_stall;
  assign last_voice = (voice == VOICE_W'(VOICE_COUNT - 1));
  assign res_free   = !res_valid || !res_stall;
  assign key        = key_lookup(scan_code);
  assign table_we   = accept && (req_type == REQ_TABLE)
                      && (table_index < TABLE_AW'(TABLE_DEPTH));

  // Remainder of the high phase bits by the odd part of the depth
  assign phase_rem = REM_W'(phase_high - prod[HIGH_W-1:0]);

  // Shared multiplier: operands follow the sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_PHASE: begin
        mul_a = MUL_AW'(sample_time);
        mul_b = MUL_BW'(note_step[voice]);
      end
      ST_MUL_RECIP: begin
        // Zero-extend the reciprocal so its top bit is not taken as a sign
        mul_a = MUL_AW'(phase_high);
        mul_b = {1'b0, RECIP_W'(RECIP)};
      end
      ST_MUL_BACK: begin
        mul_a = MUL_AW'(prod[RECIP_SHIFT +: QUOT_W]);
        mul_b = MUL_BW'(DEPTH_ODD);
      end
      ST_SCALE: begin
        mul_a = MUL_AW'(sum);
        mul_b = MUL_BW'(volume);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sine table
  kws_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (table_we),
    .waddr(table_index),
    .wdata(table_value),
    .raddr(rd_addr),
    .rdata(table_rdata)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and request stall
  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid && (req_type == REQ_TICK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (voice_held[voice]) begin
          state_next = ST_MUL_PHASE;
        end else if (last_voice) begin
          state_next = ST_SCALE;
        end
      end
      ST_MUL_PHASE: state_next = ST_MUL_RECIP;
      ST_MUL_RECIP: state_next = ST_MUL_BACK;
      ST_MUL_BACK:  state_next = ST_FIX;
      ST_FIX:       state_next = ST_READ;
      ST_READ:      state_next = ST_ACC;
      ST_ACC:       state_next = last_voice ? ST_SCALE : ST_SCAN;
      ST_SCALE:     state_next = ST_DONE;
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      note_step <= STEP_RESET;
    end else if (cfg_write) begin
      note_step[cfg_index] <= cfg_data;
    end
  end

  // Key and volume state
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_held    <= '0;
      release_armed <= 1'b0;
      volume        <= VOLUME_W'(1);
    end else if (accept && (req_type == REQ_SCAN)) begin
      if (scan_code == CODE_BREAK) begin
        release_armed <= 1'b1;
      end else if ((scan_code == CODE_VOL_UP) || (scan_code == CODE_VOL_DOWN)) begin
        if (release_armed) begin
          if (scan_code == CODE_VOL_UP) begin
            if (volume < VOLUME_W'(VOLUME_MAX)) begin
              volume <= volume + VOLUME_W'(1);
            end
          end else if (volume != '0) begin
            volume <= volume - VOLUME_W'(1);
          end
          release_armed <= 1'b0;
        end
      end else if (key.hit) begin
        if (release_armed) begin
          voice_held[key.voice] <= 1'b0;
          release_armed         <= 1'b0;
        end else begin
          voice_held[key.voice] <= 1'b1;
        end
      end else begin
        release_armed <= 1'b0;
      end
    end
  end

  // Tick datapath: phase, modulo, table read, accumulate, scale
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        voice <= '0;
        sum   <= '0;
      end
      ST_SCAN: begin
        if (!voice_held[voice] && !last_voice) begin
          voice <= voice + VOICE_W'(1);
        end
      end
      ST_MUL_PHASE, ST_MUL_RECIP, ST_MUL_BACK, ST_SCALE: begin
        prod <= mul_p;
        if (state == ST_MUL_PHASE) begin
          // Split the phase into the odd-divisor part and the low bits
          phase_high <= mul_p[DEPTH_SHIFT +: HIGH_W];
          phase_low  <= mul_p[DEPTH_SHIFT-1:0];
        end
      end
      ST_FIX: begin
        rd_addr <= {phase_rem, phase_low};
      end
      ST_ACC: begin
        sum <= sum + SUM_W'($signed(table_rdata));
        if (!last_voice) begin
          voice <= voice + VOICE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register and time advance
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      sample_time <= '0;
    end else if ((state == ST_DONE) && res_free) begin
      // Volume times eight samples always fits the output width
      res_valid    <= 1'b1;
      sample_out   <= prod[OUT_W-1:0];
      volume_level <= volume;
      if (sample_time == TIME_W'(TABLE_DEPTH - 1)) begin
        sample_time <= '0;
      end else begin
        sample_time <= sample_time + TIME_W'(1);
      end
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/kws_checker.sv
// Port-level checker for the wavetable synthesizer, bound to the top level.
// Depends on kws_pkg for the request codes and the volume limit.
module kws_checker
  import kws_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic [1:0]                    req_type,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic signed [OUT_W-1:0]       sample_out,
  input logic [VOLUME_W-1:0]           volume_level
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(sample_out) && $stable(volume_level))
    else $error("stalled result changed");

  // Keep the reported volume within its limit
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> volume_level <= VOLUME_W'(VOLUME_MAX))
    else $error("volume out of range");

  // Go busy after a tick request
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_type == REQ_TICK |=> req_stall)
    else $error("tick request did not start work");

  // Stay ready after a scan code request
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_type == REQ_SCAN |=> !req_stall)
    else $error("scan code request held the block");

  // Raise a result only at the end of tick work
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result without tick work");

endmodule

bind keyboard_wavetable_synth kws_checker u_kws_checker (.*);

>>> tb/kws_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the keyboard wavetable synthesizer: mirrors the step registers,
// sine table, key and volume state, predicts every tick's sample and checks results.
// Depends on kws_pkg.
module kws_scoreboard
  import kws_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [VOICE_W-1:0]            cfg_index,
  input  logic [STEP_W-1:0]             cfg_data,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [1:0]                    req_type,
  input  logic [7:0]                    scan_code,
  input  logic [TABLE_AW-1:0]           table_index,
  input  logic signed [SAMPLE_BITS-1:0] table_value,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  logic signed [OUT_W-1:0]       sample_out,
  input  logic [VOLUME_W-1:0]           volume_level,
  output int                            errors,
  output int                            pending
);

  localparam longint SAT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (OUT_W - 1));
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic signed [OUT_W-1:0] sample;
    logic [VOLUME_W-1:0]     level;
  } tick_result_t;

  step_t                         step_reg [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]        held;
  logic                          armed;
  logic [VOLUME_W-1:0]           vol;
  int                            now_t;
  logic signed [SAMPLE_BITS-1:0] wave_mem [TABLE_DEPTH];
  tick_result_t                  sample_q [$];

  // Update voice, release flag and volume for one scan code
  function automatic void apply_scan(code_t code);
    if (code == CODE_BREAK) begin
      armed = 1'b1;
      return;
    end
    if (code == CODE_VOL_UP || code == CODE_VOL_DOWN) begin
      // volume only moves on key release
      if (armed) begin
        if (code == CODE_VOL_UP && vol < VOLUME_MAX) vol++;
        else if (code == CODE_VOL_DOWN && vol > 0) vol--;
        armed = 1'b0;
      end
      return;
    end
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (code == KEY_CODES[v]) begin
        if (armed) begin
          held[v] = 1'b0;
          armed   = 1'b0;
        end else begin
          held[v] = 1'b1;
        end
        return;
      end
    end
    armed = 1'b0;
  endfunction

  // Mix the held voices at the current time, scale by volume, advance time
  function automatic tick_result_t mix_tick();
    tick_result_t r;
    longint acc;
    longint pos;
    acc = 0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      if (held[v]) begin
        pos = (longint'(step_reg[v]) * now_t) % TABLE_DEPTH;
        acc += longint'(wave_mem[pos]);
      end
    end
    acc = acc * longint'(vol);
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    r.sample = acc[OUT_W-1:0];
    r.level  = vol;
    now_t = (now_t + 1 >= TABLE_DEPTH) ? 0 : now_t + 1;
    return r;
  endfunction

  // Track state on every accepted request and check every accepted result
  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      step_reg = STEP_RESET;
      held     = '0;
      armed    = 1'b0;
      vol      = 1;
      now_t    = 0;
      sample_q.delete();
    end else begin
      if (cfg_write) step_reg[cfg_index] = cfg_data;

      // compare before pushing: a result never belongs to a same-cycle request
      if (res_valid && !res_stall) begin
        if (sample_q.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("%0t scoreboard: unexpected result sample_out=%0d volume_level=%0d",
                     $time, sample_out, volume_level);
          errors++;
        end else begin
          want = sample_q.pop_front();
          if (sample_out !== want.sample || volume_level !== want.level) begin
            if (errors < REPORT_MAX)
              $display({"%0t scoreboard: mismatch sample_out exp %0d got %0d,",
                        " volume_level exp %0d got %0d"},
                       $time, want.sample, sample_out, want.level, volume_level);
            errors++;
          end
        end
      end

      if (req_valid && !req_stall) begin
        case (req_t'(req_type))
          REQ_TABLE: if (table_index < TABLE_DEPTH) wave_mem[table_index] = table_value;
          REQ_SCAN:  apply_scan(scan_code);
          REQ_TICK:  sample_q.push_back(mix_tick());
          default:   ;
        endcase
      end
    end
    pending = sample_q.size();
  end

endmodule

>>> tb/tb_keyboard_wavetable_synth.sv
`timescale 1ns / 1ps
// Top of the keyboard_wavetable_synth testbench: writes the sine table entries each tick
// needs, and drives key sequences, ticks and step settings with random idling on both sides.
// Depends on kws_pkg, kws_scoreboard and the synthesizer RTL.
module tb_keyboard_wavetable_synth;
  import kws_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int BATCH         = 150;
  localparam int STEP_MAX      = 23999;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [VOICE_W-1:0]            cfg_index = '0;
  logic [STEP_W-1:0]             cfg_data = '0;
  logic                          req_valid = 1'b0;
  logic                          req_stall;
  logic [1:0]                    req_type = '0;
  logic [7:0]                    scan_code = '0;
  logic [TABLE_AW-1:0]           table_index = '0;
  logic signed [SAMPLE_BITS-1:0] table_value = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  logic signed [OUT_W-1:0]       sample_out;
  logic [VOLUME_W-1:0]           volume_level;

  logic calm = 1'b1;  // no idling on either side while set
  int   errors;
  int   pending;
  int   cycles = 0;
  int   sent = 0;

  // Stimulus-side view of the steps, the sample time and the table entries written
  step_t cur_steps [VOICE_COUNT] = STEP_RESET;
  int    tick_time = 0;
  bit    written [TABLE_DEPTH];

  keyboard_wavetable_synth dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .scan_code    (scan_code),
    .table_index  (table_index),
    .table_value  (table_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .sample_out   (sample_out),
    .volume_level (volume_level)
  );

  kws_scoreboard scoreboard (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .scan_code    (scan_code),
    .table_index  (table_index),
    .table_value  (table_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .sample_out   (sample_out),
    .volume_level (volume_level),
    .errors       (errors),
    .pending      (pending)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall results at random outside calm stretches
  always @(negedge clk) begin
    res_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  // Present one request at a falling edge and hold it until accepted
  task automatic send_req(req_t kind, code_t code, logic [TABLE_AW-1:0] idx,
                          logic signed [SAMPLE_BITS-1:0] val);
    if (!calm && $urandom_range(0, 99) < 10) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= kind;
    scan_code   <= code;
    table_index <= idx;
    table_value <= val;
    do @(posedge clk); while (req_stall);
    sent++;
    if (kind == REQ_TABLE && idx < TABLE_DEPTH) written[idx] = 1'b1;
    @(negedge clk);
  endtask

  task automatic scan(code_t code);
    send_req(REQ_SCAN, code, TABLE_AW'($urandom), SAMPLE_BITS'($urandom));
  endtask

  // Write any entry a voice reads at this time that is still unset, then tick
  task automatic tick();
    int pos;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      pos = (int'(cur_steps[v]) * tick_time) % TABLE_DEPTH;
      if (!written[pos])
        send_req(REQ_TABLE, 8'($urandom), TABLE_AW'(pos), SAMPLE_BITS'($urandom));
    end
    send_req(REQ_TICK, 8'($urandom), TABLE_AW'($urandom), SAMPLE_BITS'($urandom));
    tick_time = (tick_time + 1 >= TABLE_DEPTH) ? 0 : tick_time + 1;
  endtask

  // Write all step registers back to back, then drop the write enable once
  task automatic load_steps(input int steps [VOICE_COUNT]);
    for (int v = 0; v < VOICE_COUNT; v++) begin
      cfg_write <= 1'b1;
      cfg_index <= VOICE_W'(v);
      cfg_data  <= STEP_W'(steps[v]);
      cur_steps[v] = STEP_W'(steps[v]);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Drain all outstanding ticks, then let the sequencer go quiet
  task automatic settle();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed key traffic and ticks, with some noise mixed in
  task automatic random_batch(int count, int up_pct);
    int stop;
    int pick;
    int v;
    stop = sent + count;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      v    = $urandom_range(0, VOICE_COUNT - 1);
      if (pick < 35) begin
        tick();
      end else if (pick < 55) begin
        scan(KEY_CODES[v]);
      end else if (pick < 70) begin
        scan(CODE_BREAK);
        scan(KEY_CODES[v]);
      end else if (pick < 80) begin
        scan(CODE_BREAK);
        scan(($urandom_range(0, 99) < up_pct) ? CODE_VOL_UP : CODE_VOL_DOWN);
      end else if (pick < 85) begin
        // bare volume press, or a doubled break before a key
        if ($urandom_range(0, 1)) begin
          scan($urandom_range(0, 1) ? CODE_VOL_UP : CODE_VOL_DOWN);
        end else begin
          scan(CODE_BREAK);
          scan(CODE_BREAK);
          scan(KEY_CODES[v]);
        end
      end else if (pick < 93) begin
        scan(8'($urandom));
      end else if (pick < 98) begin
        send_req(REQ_TABLE, 8'($urandom),
                 ($urandom_range(0, 9) == 0) ? TABLE_AW'($urandom)
                                            : TABLE_AW'($urandom_range(0, TABLE_DEPTH - 1)),
                 SAMPLE_BITS'($urandom));
      end else begin
        send_req(REQ_NONE, 8'($urandom), TABLE_AW'($urandom), SAMPLE_BITS'($urandom));
      end
    end
  endtask

  initial begin
    int steps [VOICE_COUNT];

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst  <= 1'b0;
    calm <= 1'b0;

    // Table extremes and out-of-range writes, unused request type
    send_req(REQ_TABLE, 8'($urandom), '0, 24'sh7FFFFF);
    send_req(REQ_TABLE, 8'($urandom), TABLE_AW'(TABLE_DEPTH - 1), 24'sh800000);
    send_req(REQ_TABLE, 8'($urandom), TABLE_AW'(TABLE_DEPTH), 24'sd1);
    send_req(REQ_TABLE, 8'($urandom), '1, '1);
    send_req(REQ_NONE, 8'($urandom), TABLE_AW'($urandom), SAMPLE_BITS'($urandom));
    tick();
    // Hold every voice, then mix them all
    for (int v = 0; v < VOICE_COUNT; v++) scan(KEY_CODES[v]);
    tick();
    // Volume down twice from one: saturate at zero
    scan(CODE_BREAK);
    scan(CODE_VOL_DOWN);
    scan(CODE_BREAK);
    scan(CODE_VOL_DOWN);
    tick();
    // Repeated break stays armed, then releases voice 0
    scan(CODE_BREAK);
    scan(CODE_BREAK);
    scan(KEY_CODES[0]);
    // Plain code disarms, so the next key holds instead of releasing
    scan(CODE_BREAK);
    scan(8'h00);
    scan(KEY_CODES[1]);
    tick();

    random_batch(BATCH, 50);
    settle();

    // Largest steps, volume pushed up toward its ceiling
    foreach (steps[v]) steps[v] = STEP_MAX;
    load_steps(steps);
    random_batch(BATCH, 85);
    settle();

    // Zero steps, no idling, volume pushed down
    foreach (steps[v]) steps[v] = 0;
    load_steps(steps);
    calm <= 1'b1;
    random_batch(BATCH, 15);
    settle();
    calm <= 1'b0;

    foreach (steps[v]) steps[v] = $urandom_range(0, STEP_MAX);
    load_steps(steps);
    random_batch(BATCH, 50);
    settle();

    // Mix of extremes and random steps across voices
    foreach (steps[v])
      steps[v] = (v % 3 == 0) ? 0 : (v % 3 == 1) ? STEP_MAX : $urandom_range(1, STEP_MAX - 1);
    load_steps(steps);
    random_batch(BATCH, 50);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
